>>> sv/mrks_pkg.sv
// Package for the modem reply keyword spotter.
// Holds payload structs, event and kind codes, keyword texts and the matcher step.
// No dependencies.
package mrks_pkg;

  // Longest keyword, in characters, and the packed text width
  localparam int unsigned PAT_CHARS = 10;
  localparam int unsigned PAT_BITS  = 8 * PAT_CHARS;
  localparam int unsigned KW_COUNT  = 5;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Event codes
  localparam logic [2:0] EV_REPLY      = 3'd0;
  localparam logic [2:0] EV_LINE_ERR   = 3'd1;
  localparam logic [2:0] EV_OVERFLOW   = 3'd2;
  localparam logic [2:0] EV_CALL       = 3'd3;
  localparam logic [2:0] EV_SMS        = 3'd4;
  localparam logic [2:0] EV_BUSY       = 3'd5;
  localparam logic [2:0] EV_NO_CARRIER = 3'd6;
  localparam logic [2:0] EV_NO_ANSWER  = 3'd7;

  // Reply table indexes
  localparam logic [3:0] RP_OK         = 4'd0;
  localparam logic [3:0] RP_CMTI       = 4'd1;
  localparam logic [3:0] RP_PROMPT     = 4'd2;
  localparam logic [3:0] RP_CRLF       = 4'd3;
  localparam logic [3:0] RP_RING_END   = 4'd4;
  localparam logic [3:0] RP_BUSY       = 4'd5;
  localparam logic [3:0] RP_NO_CARRIER = 4'd6;
  localparam logic [3:0] RP_CPAS       = 4'd7;
  localparam logic [3:0] RP_NO_ANSWER  = 4'd8;
  localparam logic [3:0] RP_NONE       = 4'd9;

  // Pending kinds, armed by the unsolicited keywords
  localparam logic [3:0] KIND_SMS    = 4'd1;
  localparam logic [3:0] KIND_RING   = 4'd4;
  localparam logic [3:0] KIND_BUSY   = 4'd5;
  localparam logic [3:0] KIND_NOCAR  = 4'd6;
  localparam logic [3:0] KIND_NOANS  = 4'd8;
  localparam logic [3:0] KIND_NONE   = 4'd9;

  // Keyword lanes
  localparam logic [2:0] KW_RING  = 3'd0;
  localparam logic [2:0] KW_BUSY  = 3'd1;
  localparam logic [2:0] KW_NOCAR = 3'd2;
  localparam logic [2:0] KW_NOANS = 3'd3;
  localparam logic [2:0] KW_CMTI  = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       overrun_error;
    logic       parity_error;
  } mrks_in_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] line_length;
    logic       error_reply_seen;
  } mrks_out_t;

  // Result of the core for one transfer
  typedef struct packed {
    logic      valid;
    mrks_out_t data;
  } mrks_event_t;

  // Keyword text, first character in the top byte, and its length
  typedef struct packed {
    logic [PAT_BITS-1:0] txt;
    logic [3:0]          len;
  } pat_t;

  typedef struct packed {
    logic [3:0] pos;
    logic       hit;
  } step_t;

  function automatic pat_t mk_pat(logic [PAT_BITS-1:0] txt, logic [3:0] len);
    pat_t p;
    p.txt = txt;
    p.len = len;
    return p;
  endfunction

  localparam pat_t PAT_NONE  = '0;
  localparam pat_t PAT_CRLF  = '{txt: {CH_CR, CH_LF, 64'h0}, len: 4'd2};
  localparam pat_t PAT_RINGE = '{txt: {",0", CH_CR, CH_LF, 48'h0}, len: 4'd4};
  localparam pat_t PAT_ERROR = '{txt: {"ERROR", 40'h0}, len: 4'd5};
  localparam pat_t PAT_BUSY  = '{txt: {"BUSY", 48'h0}, len: 4'd4};
  localparam pat_t PAT_NOCAR = '{txt: "NO CARRIER", len: 4'd10};
  localparam pat_t PAT_NOANS = '{txt: {"NO ANSWER", 8'h0}, len: 4'd9};
  localparam pat_t PAT_CMTI  = '{txt: {"+CMTI: ", 24'h0}, len: 4'd7};
  localparam pat_t PAT_RING  = '{txt: {"RING", 48'h0}, len: 4'd4};

  // Awaited reply text; unused indexes never match
  function automatic pat_t reply_pat(logic [3:0] idx);
    pat_t p;
    case (idx)
      RP_OK:         p = mk_pat({"OK", CH_CR, CH_LF, 48'h0}, 4'd4);
      RP_CMTI:       p = PAT_CMTI;
      RP_PROMPT:     p = mk_pat({"> ", 64'h0}, 4'd2);
      RP_CRLF:       p = PAT_CRLF;
      RP_RING_END:   p = PAT_RINGE;
      RP_BUSY:       p = PAT_BUSY;
      RP_NO_CARRIER: p = PAT_NOCAR;
      RP_CPAS:       p = mk_pat({"CPAS", 48'h0}, 4'd4);
      RP_NO_ANSWER:  p = PAT_NOANS;
      default:       p = PAT_NONE;
    endcase
    return p;
  endfunction

  function automatic pat_t kw_pat(logic [2:0] lane);
    pat_t p;
    case (lane)
      KW_RING:  p = PAT_RING;
      KW_BUSY:  p = PAT_BUSY;
      KW_NOCAR: p = PAT_NOCAR;
      KW_NOANS: p = PAT_NOANS;
      KW_CMTI:  p = PAT_CMTI;
      default:  p = PAT_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] kw_kind(logic [2:0] lane);
    logic [3:0] k;
    case (lane)
      KW_RING:  k = KIND_RING;
      KW_BUSY:  k = KIND_BUSY;
      KW_NOCAR: k = KIND_NOCAR;
      KW_NOANS: k = KIND_NOANS;
      KW_CMTI:  k = KIND_SMS;
      default:  k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Terminator awaited after an unsolicited keyword
  function automatic pat_t pending_pat(logic [3:0] kind);
    pat_t p;
    case (kind)
      KIND_RING:  p = PAT_RINGE;
      KIND_SMS,
      KIND_BUSY,
      KIND_NOCAR,
      KIND_NOANS: p = PAT_CRLF;
      default:    p = PAT_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] pending_event(logic [3:0] kind);
    logic [2:0] e;
    case (kind)
      KIND_RING:  e = EV_CALL;
      KIND_SMS:   e = EV_SMS;
      KIND_BUSY:  e = EV_BUSY;
      KIND_NOCAR: e = EV_NO_CARRIER;
      default:    e = EV_NO_ANSWER;
    endcase
    return e;
  endfunction

  // One naive matcher step: advance on a hit, restart on a miss
  function automatic step_t match_step(pat_t p, logic [3:0] pos, logic [7:0] b);
    step_t      s;
    logic [7:0] c;
    logic [3:0] np;
    c = 8'h00;
    for (int i = 0; i < PAT_CHARS; i++) begin
      if (pos == 4'(i)) c = p.txt[PAT_BITS-1-8*i -: 8];
    end
    np = pos + 4'd1;
    s.pos = 4'd0;
    s.hit = 1'b0;
    if (!b[7] && (pos < p.len) && (c == b)) begin
      if (np >= p.len) s.hit = 1'b1;
      else s.pos = np;
    end
    return s;
  endfunction

endpackage

>>> sv/mrks_core.sv
// Matcher bank of the keyword spotter: line count, match state and event decode.
// Depends on mrks_pkg.
module mrks_core
  import mrks_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  mrks_in_t    item,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data,
  output mrks_event_t ev
);

  logic [7:0] byte_count, byte_count_next;
  logic [3:0] primary_pattern, primary_pattern_next;
  logic [3:0] primary_pos, primary_pos_next;
  logic [2:0] error_kw_pos, error_kw_pos_next;
  logic [3:0] pending_kind, pending_kind_next;
  logic [2:0] pending_pos, pending_pos_next;
  logic [3:0] keyword_pos [KW_COUNT];
  logic [3:0] keyword_pos_next [KW_COUNT];
  logic       error_flag, error_flag_next;

  logic       line_err;
  logic [7:0] count_inc;
  step_t      prim_s, err_s, pend_s;
  step_t      kw_s [KW_COUNT];

  assign line_err  = item.framing_error | item.overrun_error | item.parity_error;
  assign count_inc = byte_count + 8'd1;

  // Run every matcher on the byte; priority is applied below
  always_comb begin
    prim_s = match_step(reply_pat(primary_pattern), primary_pos, item.rx_byte);
    err_s  = match_step(PAT_ERROR, {1'b0, error_kw_pos}, item.rx_byte);
    pend_s = match_step(pending_pat(pending_kind), {1'b0, pending_pos}, item.rx_byte);
    for (int i = 0; i < KW_COUNT; i++) begin
      kw_s[i] = match_step(kw_pat(3'(i)), keyword_pos[i], item.rx_byte);
    end
  end

  // Next state and event for one transfer
  always_comb begin
    byte_count_next      = byte_count;
    primary_pattern_next = primary_pattern;
    primary_pos_next     = primary_pos;
    error_kw_pos_next    = error_kw_pos;
    pending_kind_next    = pending_kind;
    pending_pos_next     = pending_pos;
    error_flag_next      = error_flag;
    for (int i = 0; i < KW_COUNT; i++) keyword_pos_next[i] = keyword_pos[i];
    ev = '0;

    if (accept) begin
      if (line_err || (byte_count >= 8'(LINE_CAPACITY))) begin
        byte_count_next    = 8'd0;
        ev.valid           = 1'b1;
        ev.data.event_code = line_err ? EV_LINE_ERR : EV_OVERFLOW;
      end else begin
        byte_count_next  = count_inc;
        primary_pos_next = prim_s.pos;
        if (prim_s.hit) begin
          // Reply complete: later matchers do not see this byte
          ev.valid                 = 1'b1;
          ev.data.event_code       = EV_REPLY;
          ev.data.line_length      = count_inc;
          ev.data.error_reply_seen = error_flag;
          byte_count_next          = 8'd0;
        end else begin
          error_kw_pos_next = err_s.pos[2:0];
          if (err_s.hit) begin
            primary_pattern_next = RP_CRLF;
            primary_pos_next     = 4'd0;
            error_flag_next      = 1'b1;
          end
          pending_pos_next = pend_s.pos[2:0];
          if (pend_s.hit) begin
            pending_kind_next   = KIND_NONE;
            pending_pos_next    = 3'd0;
            ev.valid            = 1'b1;
            ev.data.event_code  = pending_event(pending_kind);
            ev.data.line_length = count_inc;
            byte_count_next     = 8'd0;
          end else begin
            // Last keyword to complete wins
            for (int i = 0; i < KW_COUNT; i++) begin
              keyword_pos_next[i] = kw_s[i].pos;
              if (kw_s[i].hit) begin
                pending_kind_next = kw_kind(3'(i));
                pending_pos_next  = 3'd0;
              end
            end
          end
        end
      end
    end

    // Register write reloads the primary matcher
    if (cfg_write) begin
      primary_pattern_next = cfg_data;
      primary_pos_next     = 4'd0;
      error_flag_next      = 1'b0;
    end
  end

  // Hold match state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= 8'd0;
      primary_pattern <= RP_NONE;
      primary_pos     <= 4'd0;
      error_kw_pos    <= 3'd0;
      pending_kind    <= KIND_NONE;
      pending_pos     <= 3'd0;
      error_flag      <= 1'b0;
      for (int i = 0; i < KW_COUNT; i++) keyword_pos[i] <= 4'd0;
    end else begin
      byte_count      <= byte_count_next;
      primary_pattern <= primary_pattern_next;
      primary_pos     <= primary_pos_next;
      error_kw_pos    <= error_kw_pos_next;
      pending_kind    <= pending_kind_next;
      pending_pos     <= pending_pos_next;
      error_flag      <= error_flag_next;
      for (int i = 0; i < KW_COUNT; i++) keyword_pos[i] <= keyword_pos_next[i];
    end
  end

endmodule

>>> sv/mrks_outreg.sv
// Result register of the keyword spotter, one event deep.
// Depends on mrks_pkg.
module mrks_outreg
  import mrks_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mrks_event_t ev,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output mrks_out_t   out_data
);

  // Blocked when a result is held and the receiver stalls
  assign full = out_valid & out_stall;

  // Load a new result once the held one is transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!full) begin
      out_valid <= ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && ev.valid) begin
      out_data <= ev.data;
    end
  end

endmodule

>>> sv/modem_reply_keyword_spotter_top.sv
// Modem reply keyword spotter, top level.
// Takes one received byte per transfer with its line-error flags and emits
// at most one event per byte: reply ready, line error, overflow, call, SMS,
// busy, no carrier or no answer, with the line byte count.
// Input channel in_valid/in_stall/in_data; output channel out_valid/
// out_stall/out_data; a transfer happens when valid is high and stall low.
// The awaited reply index is written through cfg_write/cfg_data while idle.
// An event appears on out_valid in the cycle after its byte is
// transferred. One byte per cycle is taken while no result waits under
// out_stall; the combinational matcher bank feeds a one-deep result register.
// Bytes flow freely while the result register is empty or being transferred.
// While a result waits under out_stall, in_stall is raised for every byte,
// whether or not it would raise an event, and the held result stays unchanged.
// Reset (rst, synchronous) clears the count and all matchers, sets the
// awaited reply to none and empties the result register.
// Depends on mrks_pkg, mrks_core and mrks_outreg.
module modem_reply_keyword_spotter_top
  import mrks_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  mrks_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output mrks_out_t  out_data,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data
);

  logic        accept;
  logic        full;
  mrks_event_t ev;

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  mrks_core #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .ev       (ev)
  );

  mrks_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> dv/tb.sv
// Testbench for modem_reply_keyword_spotter_top: drives received bytes through the
// valid/stall channel, predicts every event in a model of the matchers and checks it.
// Depends on mrks_pkg and the RTL under sv/.
module tb;
  import mrks_pkg::*;

  localparam int unsigned LINE_CAP    = 128;
  localparam int unsigned HOLD_LEN    = 60;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 62;
  // Reply indexes past the table, both of which never match
  localparam logic [3:0] RP_FIRST_SPARE = 4'd10;
  localparam logic [3:0] RP_LAST_SPARE  = 4'd15;
  localparam string CRLF_TXT  = "\015\012";
  localparam string ERROR_TXT = "ERROR";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  mrks_in_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  mrks_out_t  out_data;
  logic       cfg_write = 1'b0;
  logic [3:0] cfg_data = 4'd0;

  modem_reply_keyword_spotter_top #(
    .LINE_CAPACITY(LINE_CAP)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keyword lanes in matcher order
  string      kw_text [KW_COUNT] = '{"RING", "BUSY", "NO CARRIER", "NO ANSWER", "+CMTI: "};
  logic [3:0] kw_kind_tab [KW_COUNT] = '{KIND_RING, KIND_BUSY, KIND_NOCAR, KIND_NOANS,
                                         KIND_SMS};

  // Spotter model state
  logic [7:0] line_cnt;
  logic [3:0] reply_sel;
  logic [3:0] reply_pos;
  logic [3:0] err_pos;
  logic [3:0] term_kind;
  logic [3:0] term_pos;
  logic [3:0] kw_pos [KW_COUNT];
  logic       err_seen;

  mrks_in_t  rx_backlog[$];
  mrks_out_t due_events[$];

  int send_idle_pct = 12;
  int stall_pct     = 85;
  bit hold_go       = 1'b0;
  int hold_cnt;
  int bytes_queued  = 0;
  int bytes_taken   = 0;
  int reply_writes  = 0;
  int mismatch_cnt  = 0;
  int ev_count [8]  = '{default: 0};
  int cycle_cnt     = 0;

  function automatic string reply_text(logic [3:0] sel);
    case (sel)
      RP_OK:         return {"OK", CRLF_TXT};
      RP_CMTI:       return "+CMTI: ";
      RP_PROMPT:     return "> ";
      RP_CRLF:       return CRLF_TXT;
      RP_RING_END:   return {",0", CRLF_TXT};
      RP_BUSY:       return "BUSY";
      RP_NO_CARRIER: return "NO CARRIER";
      RP_CPAS:       return "CPAS";
      RP_NO_ANSWER:  return "NO ANSWER";
      default:       return "";
    endcase
  endfunction

  function automatic string terminator_text(logic [3:0] kind);
    case (kind)
      KIND_RING:                               return {",0", CRLF_TXT};
      KIND_SMS, KIND_BUSY, KIND_NOCAR, KIND_NOANS: return CRLF_TXT;
      default:                                 return "";
    endcase
  endfunction

  function automatic logic [2:0] terminator_event(logic [3:0] kind);
    case (kind)
      KIND_RING:  return EV_CALL;
      KIND_SMS:   return EV_SMS;
      KIND_BUSY:  return EV_BUSY;
      KIND_NOCAR: return EV_NO_CARRIER;
      default:    return EV_NO_ANSWER;
    endcase
  endfunction

  // Naive match: {completed, next position}; a miss restarts without retesting
  function automatic logic [4:0] advance_pat(string pat, logic [3:0] pos, logic [7:0] b);
    if (!b[7] && int'(pos) < pat.len() && pat[pos] == b) begin
      if (int'(pos) + 1 >= pat.len()) return {1'b1, 4'd0};
      return {1'b0, pos + 4'd1};
    end
    return 5'd0;
  endfunction

  task automatic clear_spotter();
    line_cnt  = '0;
    reply_sel = RP_NONE;
    reply_pos = '0;
    err_pos   = '0;
    term_kind = KIND_NONE;
    term_pos  = '0;
    foreach (kw_pos[i]) kw_pos[i] = '0;
    err_seen  = 1'b0;
  endtask

  // Work out the event, if any, that one accepted byte raises
  task automatic spot_byte(input mrks_in_t it);
    mrks_out_t  ev;
    logic [4:0] st;
    logic       faulty;
    faulty = it.framing_error | it.overrun_error | it.parity_error;
    if (faulty || line_cnt >= LINE_CAP) begin
      ev.event_code       = faulty ? EV_LINE_ERR : EV_OVERFLOW;
      ev.line_length      = '0;
      ev.error_reply_seen = 1'b0;
      line_cnt = '0;
      due_events.push_back(ev);
      return;
    end
    line_cnt = line_cnt + 8'd1;

    st = advance_pat(reply_text(reply_sel), reply_pos, it.rx_byte);
    reply_pos = st[3:0];
    if (st[4]) begin
      ev.event_code       = EV_REPLY;
      ev.line_length      = line_cnt;
      ev.error_reply_seen = err_seen;
      line_cnt = '0;
      due_events.push_back(ev);
      return;
    end

    // ERROR redirects the awaited reply to a bare line end
    st = advance_pat(ERROR_TXT, err_pos, it.rx_byte);
    err_pos = st[3:0];
    if (st[4]) begin
      reply_sel = RP_CRLF;
      reply_pos = '0;
      err_seen  = 1'b1;
    end

    st = advance_pat(terminator_text(term_kind), term_pos, it.rx_byte);
    term_pos = st[3:0];
    if (st[4]) begin
      ev.event_code       = terminator_event(term_kind);
      ev.line_length      = line_cnt;
      ev.error_reply_seen = 1'b0;
      term_kind = KIND_NONE;
      term_pos  = '0;
      line_cnt  = '0;
      due_events.push_back(ev);
      return;
    end

    // Last keyword to complete arms the terminator
    for (int lane = 0; lane < KW_COUNT; lane++) begin
      st = advance_pat(kw_text[lane], kw_pos[lane], it.rx_byte);
      kw_pos[lane] = st[3:0];
      if (st[4]) begin
        term_kind = kw_kind_tab[lane];
        term_pos  = '0;
      end
    end
  endtask

  // Sender: predict on each transfer, then offer the next byte or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        spot_byte(in_data);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= rx_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold on request, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_go && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    mrks_out_t want;
    if (!rst && out_valid && !out_stall) begin
      ev_count[out_data.event_code]++;
      if (due_events.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected event, expected none, actual code %0d length %0d err %0d",
                 $time, out_data.event_code, out_data.line_length,
                 out_data.error_reply_seen);
      end else begin
        want = due_events.pop_front();
        if (want.event_code !== out_data.event_code) begin
          mismatch_cnt++;
          $display("%0t: event_code expected %0d actual %0d", $time,
                   want.event_code, out_data.event_code);
        end
        if (want.line_length !== out_data.line_length) begin
          mismatch_cnt++;
          $display("%0t: line_length expected %0d actual %0d", $time,
                   want.line_length, out_data.line_length);
        end
        if (want.error_reply_seen !== out_data.error_reply_seen) begin
          mismatch_cnt++;
          $display("%0t: error_reply_seen expected %0d actual %0d", $time,
                   want.error_reply_seen, out_data.error_reply_seen);
        end
      end
    end
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d events outstanding", CYCLE_LIMIT,
               due_events.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_byte(logic [7:0] b, logic [2:0] flt);
    mrks_in_t it;
    it.rx_byte       = b;
    it.framing_error = flt[2];
    it.overrun_error = flt[1];
    it.parity_error  = flt[0];
    rx_backlog.push_back(it);
    bytes_queued++;
  endtask

  task automatic queue_text(string s, int fault_pct);
    logic [2:0] flt;
    for (int i = 0; i < s.len(); i++) begin
      flt = ($urandom_range(0, 99) < fault_pct) ? 3'($urandom_range(1, 7)) : 3'd0;
      queue_byte(s[i], flt);
    end
  endtask

  // Wait until every byte is taken and every event seen, then let the pipe drain
  task automatic drain();
    while (rx_backlog.size() != 0 || in_valid || due_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reply(logic [3:0] sel);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= sel;
    @(posedge clk);
    cfg_write <= 1'b0;
    reply_sel = sel;
    reply_pos = '0;
    err_seen  = 1'b0;
    reply_writes++;
    @(negedge clk);
  endtask

  // Mostly complete replies and unsolicited lines, with noise and cut-off keywords
  task automatic fill_random(int target);
    int    start;
    int    r;
    string w;
    string tok;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 10))
          0, 1:    tok = (reply_text(reply_sel) == "") ? {"OK", CRLF_TXT}
                                                       : reply_text(reply_sel);
          2:       tok = {"RING,0", CRLF_TXT};
          3:       tok = {"BUSY", CRLF_TXT};
          4:       tok = {"NO CARRIER", CRLF_TXT};
          5:       tok = {"NO ANSWER", CRLF_TXT};
          6:       tok = {"+CMTI: \"SM\",3", CRLF_TXT};
          7:       tok = {ERROR_TXT, CRLF_TXT};
          8:       tok = {"OK", CRLF_TXT};
          9:       tok = "> ";
          default: tok = "CPAS";
        endcase
        queue_text(tok, 2);
      end else if (r < 85) begin
        queue_byte(8'($urandom_range(32, 126)), 3'd0);
      end else if (r < 92) begin
        queue_byte(8'($urandom_range(0, 255)), 3'd0);
      end else if (r < 97) begin
        w = kw_text[$urandom_range(0, KW_COUNT - 1)];
        queue_text(w.substr(0, $urandom_range(0, w.len() - 2)), 0);
      end else begin
        queue_byte(8'($urandom_range(0, 255)), 3'($urandom_range(1, 7)));
      end
    end
  endtask

  logic [3:0] reply_plan [12] = '{RP_OK, RP_CMTI, RP_PROMPT, RP_CRLF, RP_RING_END,
                                  RP_NONE, RP_BUSY, RP_NO_CARRIER, RP_CPAS,
                                  RP_NO_ANSWER, RP_LAST_SPARE, RP_FIRST_SPARE};

  initial begin
    clear_spotter();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: plain reply, incoming call, each line fault, ERROR redirect
    write_reply(RP_OK);
    queue_text({"OK", CRLF_TXT}, 0);
    queue_text({"RING,0", CRLF_TXT}, 0);
    queue_byte(8'hFF, 3'b100);
    queue_byte(8'h00, 3'b010);
    queue_byte(8'h80, 3'b001);
    queue_byte(8'hFF, 3'b000);
    queue_text({ERROR_TXT, CRLF_TXT}, 0);
    drain();

    // Long output hold while bytes keep coming
    write_reply(RP_BUSY);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b1;
    for (int k = 0; k < 10; k++) begin
      queue_text("BUSY", 0);
      queue_byte(8'($urandom_range(0, 255)), 3'($urandom_range(1, 7)));
    end
    drain();

    // Random lines under every reply setting and three idling regimes
    for (int p = 0; p < 12; p++) begin
      write_reply(reply_plan[p]);
      send_idle_pct = (p < 4) ? 12 : (p < 8) ? 85 : 0;
      stall_pct     = (p < 4) ? 85 : (p < 8) ? 12 : 0;
      if (p == 5 || p == 10) begin
        // Start from a clear count, then run past the line capacity
        queue_byte(8'h00, 3'b010);
        for (int k = $urandom_range(129, 134); k > 0; k--)
          queue_byte($urandom_range(0, 1) ? 8'h7A : 8'($urandom_range(128, 255)), 3'd0);
      end
      fill_random(PHASE_BYTES);
      drain();
    end

    $display("Covered %0d bytes under %0d reply settings, with idling on both sides and a long output hold.",
             bytes_taken, reply_writes);
    $display("Events: reply %0d, line error %0d, overflow %0d, call %0d, sms %0d, busy %0d, no carrier %0d, no answer %0d",
             ev_count[EV_REPLY], ev_count[EV_LINE_ERR], ev_count[EV_OVERFLOW],
             ev_count[EV_CALL], ev_count[EV_SMS], ev_count[EV_BUSY],
             ev_count[EV_NO_CARRIER], ev_count[EV_NO_ANSWER]);
    if (mismatch_cnt == 0 && due_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
